[hw/rtl/h264d_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the H.264 RTP depacketizer.
// No dependencies; compiled first.
package h264d_pkg;

    localparam int BYTE_W    = 8;
    localparam int HDR_CNT_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int SC_LEN_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RTP_HDR_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEI_SHORT_SC  = 1'd1;

    localparam logic [HDR_CNT_W-1:0] RTP_HDR_RESET = 7'd12;
    localparam logic [HDR_CNT_W-1:0] HDR_CNT_MAX   = 7'd127;

    // NAL unit types
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;
    localparam logic [4:0] NAL_FU_A  = 5'd28;

    // start code lengths
    localparam logic [SC_LEN_W-1:0] SC_NONE  = 3'd0;
    localparam logic [SC_LEN_W-1:0] SC_SHORT = 3'd3;
    localparam logic [SC_LEN_W-1:0] SC_LONG  = 3'd4;

    // packet parse state codes
    localparam logic [1:0] KIND_WAIT  = 2'd0;
    localparam logic [1:0] KIND_FUHDR = 2'd1;
    localparam logic [1:0] KIND_PASS  = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

[hw/rtl/h264d_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one RTP packet byte per transfer with an end-of-packet flag.
// Depends on h264d_pkg.
interface h264d_in_if;
    logic               valid;
    logic               ready;
    h264d_pkg::t_byte   in_byte;
    logic               packet_end;

    modport source (output valid, output in_byte, output packet_end, input ready);
    modport sink   (input valid, input in_byte, input packet_end, output ready);
endinterface

[hw/rtl/h264d_out_if.sv]
`timescale 1ns / 1ps
// Output channel: one Annex B stream byte per transfer plus status flags.
// Depends on h264d_pkg.
interface h264d_out_if;
    logic               valid;
    logic               ready;
    h264d_pkg::t_byte   out_byte;
    logic               unit_start;
    logic               short_packet;
    logic               run_last;

    modport source (output valid, output out_byte, output unit_start,
                    output short_packet, output run_last, input ready);
    modport sink   (input valid, input out_byte, input unit_start,
                    input short_packet, input run_last, output ready);
endinterface

[hw/rtl/h264_rtp_depacketizer.sv]
`timescale 1ns / 1ps
// H.264 RTP depacketizer top level: RTP bytes in, Annex B bytes out.
// Depends on h264d_pkg, h264d_in_if, h264d_out_if.
//
// Usage:
//   i_in carries one packet byte per transfer; packet_end marks the last byte
//   of each RTP packet. o_out carries stream bytes; run_last flags the last
//   byte produced by a given input byte, short_packet flags an error result.
//   The config port (i_cfg_we/i_cfg_idx/i_cfg_data) sets the RTP header size
//   and the SEI start code length; write it only while the block is idle.
// Timing:
//   An input byte is held in the input register, is parsed, and its
//   results are loaded into the result register. The result register
//   sends one byte per cycle while the receiver is ready, so a plain
//   payload byte yields one stream byte and a NAL header with its start
//   code yields 4 or 5; dropped and skipped bytes yield none. Throughput
//   is one input byte per cycle on payload while the receiver is ready.
// Reset clears the parse state and both registers; config returns to
//   12 header bytes and 3-byte SEI start codes.
// A stalled receiver holds the current result; one more input byte is taken
//   into the input register, then i_in.ready drops.
module h264_rtp_depacketizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    h264d_in_if.sink                          i_in,
    h264d_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [h264d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [h264d_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import h264d_pkg::*;

    // config
    logic [HDR_CNT_W-1:0] r_hdr_bytes;
    logic                 r_sei_short;

    // input register
    logic                 r_in_valid;
    t_byte                r_in_byte;
    logic                 r_in_end;

    // parse state
    logic [HDR_CNT_W-1:0] r_byte_index, n_byte_index;
    logic [1:0]           r_kind, n_kind;
    logic                 r_in_frag, n_in_frag;
    t_byte                r_indicator, n_indicator;

    // result register: optional start code, then one data or error result
    logic                 r_run_valid;
    logic [SC_LEN_W-1:0]  r_sc_len, n_sc_len;
    t_byte                r_run_byte, n_run_byte;
    logic                 r_run_err, n_run_err;
    logic                 n_produce;
    logic [SC_LEN_W-1:0]  r_pos;

    logic                 w_run_last;
    logic                 w_out_xfer;
    logic                 w_load;
    logic [4:0]           w_type;

    assign w_run_last = (r_pos == r_sc_len);
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign w_load     = r_in_valid && (!r_run_valid || (w_out_xfer && w_run_last));
    assign i_in.ready = !r_in_valid || w_load;
    assign w_type     = r_in_byte[4:0];

    // output decode
    always_comb begin
        o_out.valid        = r_run_valid;
        o_out.run_last     = w_run_last;
        o_out.unit_start   = 1'b0;
        o_out.short_packet = 1'b0;
        o_out.out_byte     = '0;
        if (r_pos < r_sc_len) begin
            o_out.unit_start = (r_pos == '0);
            o_out.out_byte   = (r_pos == r_sc_len - SC_LEN_W'(1)) ? t_byte'(1) : '0;
        end else begin
            o_out.short_packet = r_run_err;
            o_out.out_byte     = r_run_err ? '0 : r_run_byte;
        end
    end

    // parse one byte
    always_comb begin
        n_byte_index = r_byte_index;
        n_kind       = r_kind;
        n_in_frag    = r_in_frag;
        n_indicator  = r_indicator;
        n_sc_len     = SC_NONE;
        n_run_byte   = r_in_byte;
        n_run_err    = 1'b0;
        n_produce    = 1'b0;
        unique case (r_kind)
            KIND_WAIT: begin
                if (r_byte_index < r_hdr_bytes) begin
                    if (r_byte_index != HDR_CNT_MAX) begin
                        n_byte_index = r_byte_index + HDR_CNT_W'(1);
                    end
                    n_run_err = r_in_end;
                end else if (w_type == NAL_FU_A) begin
                    n_indicator = r_in_byte;
                    n_kind      = KIND_FUHDR;
                    n_run_err   = r_in_end;
                end else begin
                    n_in_frag = 1'b0;
                    case (w_type) inside
                        NAL_SLICE, NAL_IDR, NAL_SPS, NAL_PPS: begin
                            n_sc_len  = SC_LONG;
                            n_produce = 1'b1;
                            n_kind    = KIND_PASS;
                        end
                        NAL_SEI: begin
                            n_sc_len  = r_sei_short ? SC_SHORT : SC_LONG;
                            n_produce = 1'b1;
                            n_kind    = KIND_PASS;
                        end
                        default: begin
                            n_kind = KIND_DROP;
                        end
                    endcase
                end
            end
            KIND_FUHDR: begin
                if (r_in_byte[7]) begin
                    n_sc_len   = SC_LONG;
                    n_run_byte = {r_indicator[7:5], w_type};
                    n_produce  = 1'b1;
                    n_kind     = KIND_PASS;
                    n_in_frag  = !r_in_byte[6];
                end else if (r_in_frag) begin
                    n_kind    = KIND_PASS;
                    n_in_frag = !r_in_byte[6];
                end else begin
                    n_kind = KIND_DROP;
                end
            end
            KIND_PASS: begin
                n_produce = 1'b1;
            end
            KIND_DROP: begin
            end
            default: begin
            end
        endcase
        if (n_run_err) begin
            n_in_frag = 1'b0;
            n_produce = 1'b1;
        end
        if (r_in_end) begin
            n_byte_index = '0;
            n_kind       = KIND_WAIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_bytes  <= RTP_HDR_RESET;
            r_sei_short  <= 1'b1;
            r_in_valid   <= 1'b0;
            r_byte_index <= '0;
            r_kind       <= KIND_WAIT;
            r_in_frag    <= 1'b0;
            r_indicator  <= '0;
            r_run_valid  <= 1'b0;
            r_pos        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RTP_HDR_BYTES: r_hdr_bytes <= i_cfg_data;
                    CFG_SEI_SHORT_SC:  r_sei_short <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end
            if (w_load) begin
                r_byte_index <= n_byte_index;
                r_kind       <= n_kind;
                r_in_frag    <= n_in_frag;
                r_indicator  <= n_indicator;
                r_run_valid  <= n_produce;
                r_pos        <= '0;
            end else if (w_out_xfer) begin
                if (w_run_last) begin
                    r_run_valid <= 1'b0;
                end
                r_pos <= r_pos + SC_LEN_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.packet_end;
        end
        if (w_load) begin
            r_sc_len   <= n_sc_len;
            r_run_byte <= n_run_byte;
            r_run_err  <= n_run_err;
        end
    end

endmodule
